@@ rtl/crc32_byte_stream_top_assert.svh @@
// ----------------------------------------------------------------------------
// CRC-32 byte stream assertion macros
// Shared property wrappers for the checker of the byte stream CRC block.
// ----------------------------------------------------------------------------
`ifndef CRC32_BYTE_STREAM_TOP_ASSERT_SVH
`define CRC32_BYTE_STREAM_TOP_ASSERT_SVH

// Assert that an implication holds on every clock edge outside reset.
`define CRCBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Assert that a condition never holds on any clock edge outside reset.
`define CRCBS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

@@ rtl/crcbs_pkg.sv @@
// ----------------------------------------------------------------------------
// CRC-32 byte stream package
// Shared word type and the reflected CRC-32 byte fold.
// ----------------------------------------------------------------------------
package crcbs_pkg;

  // Reflected CRC-32 polynomial.
  localparam logic [31:0] CrcPoly = 32'hEDB88320;

  // One input word as it travels through the input register.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } crcbs_item_t;

  // Fold one byte into the remainder, least significant bit first.
  // The eight shift and conditional XOR steps form a flat XOR network.
  function automatic logic [31:0] crc_fold_byte(input logic [31:0] rem,
                                                input logic [7:0]  data);
    logic [31:0] x;
    x = rem ^ {24'h000000, data};
    for (int k = 0; k < 8; k++) begin
      if (x[0]) begin
        x = (x >> 1) ^ CrcPoly;
      end else begin
        x = x >> 1;
      end
    end
    return x;
  endfunction

endpackage

@@ rtl/crcbs_in_stage.sv @@
// ----------------------------------------------------------------------------
// CRC-32 byte stream input register
// Captures one input word per cycle unless stalled and holds it until the fold takes it.
// ----------------------------------------------------------------------------
module crcbs_in_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  crcbs_pkg::crcbs_item_t in_item_i,
  input  logic                  advance_i,
  output logic                  in_stall_o,
  output logic                  valid_o,
  output crcbs_pkg::crcbs_item_t item_o
);
  import crcbs_pkg::*;

  logic        valid_q, valid_d;
  crcbs_item_t item_q;
  logic        load;

  // The register takes a new word when it is empty or draining this cycle.
  assign in_stall_o = valid_q & ~advance_i;
  assign load       = in_valid_i & ~in_stall_o;
  assign valid_d    = load | (valid_q & ~advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ rtl/crcbs_fold.sv @@
// ----------------------------------------------------------------------------
// CRC-32 byte stream fold unit
// Holds the running remainder and folds one byte into it per cycle while words advance.
// ----------------------------------------------------------------------------
module crcbs_fold (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  advance_i,
  input  crcbs_pkg::crcbs_item_t item_i,
  output logic [31:0]           crc_next_o
);
  import crcbs_pkg::*;

  logic [31:0] remainder_q, remainder_d;
  logic [31:0] start_rem;

  // A first byte restarts the remainder at zero before it is folded in.
  assign start_rem   = item_i.first_byte ? 32'h0000_0000 : remainder_q;
  assign crc_next_o  = crc_fold_byte(start_rem, item_i.data_byte);
  assign remainder_d = advance_i ? crc_next_o : remainder_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remainder_q <= 32'h0000_0000;
    end else begin
      remainder_q <= remainder_d;
    end
  end

endmodule

@@ rtl/crcbs_out_stage.sv @@
// ----------------------------------------------------------------------------
// CRC-32 byte stream result register
// Holds a finished CRC word until the downstream side takes it.
// ----------------------------------------------------------------------------
module crcbs_out_stage (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  logic [31:0] crc_i,
  input  logic        out_stall_i,
  output logic        free_o,
  output logic        out_valid_o,
  output logic [31:0] crc_value_o
);

  logic        valid_q, valid_d;
  logic [31:0] crc_q;

  // The register can take a word when it is empty or being read out.
  assign free_o  = ~valid_q | ~out_stall_i;
  assign valid_d = load_i | (valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      crc_q <= crc_i;
    end
  end

  assign out_valid_o = valid_q;
  assign crc_value_o = crc_q;

endmodule

@@ rtl/crc32_byte_stream_top.sv @@
// A result word passes through the input register and then the result register
// after its last byte is accepted, and waits while the result register is not free.
// Throughput: one byte per cycle unless stalled; the byte fold is an XOR network.
// Input stalls only when a last byte waits behind a result that is not taken.
// Reset clears the running remainder to zero and empties both registers.
// ----------------------------------------------------------------------------
// CRC-32 byte stream top level
// Reflected CRC-32, zero start value, no final inversion, one byte per word.
// ----------------------------------------------------------------------------
module crc32_byte_stream_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] crc_value_o
);
  import crcbs_pkg::*;

  crcbs_item_t in_item;
  crcbs_item_t s1_item;
  logic        s1_valid;
  logic        s1_advance;
  logic        out_free;
  logic        out_load;
  logic [31:0] crc_next;

  assign in_item.data_byte  = data_byte_i;
  assign in_item.first_byte = first_byte_i;
  assign in_item.last_byte  = last_byte_i;

  // A held word moves on unless it is a last byte and the result is blocked.
  assign s1_advance = s1_valid & (~s1_item.last_byte | out_free);
  assign out_load   = s1_advance & s1_item.last_byte;

  crcbs_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item),
    .advance_i  (s1_advance),
    .in_stall_o (in_stall_o),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  crcbs_fold u_fold (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (s1_advance),
    .item_i     (s1_item),
    .crc_next_o (crc_next)
  );

  crcbs_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (out_load),
    .crc_i       (crc_next),
    .out_stall_i (out_stall_i),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .crc_value_o (crc_value_o)
  );

endmodule

@@ rtl/crcbs_checker.sv @@
// ----------------------------------------------------------------------------
// CRC-32 byte stream checker
// Port-level assertions on the byte stream CRC block, bound to the top level.
// ----------------------------------------------------------------------------
`include "crc32_byte_stream_top_assert.svh"

module crcbs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] crc_value_o
);

  logic in_fire;
  logic out_blocked;
  logic quiet;

  assign in_fire     = in_valid_i & ~in_stall_o;
  assign out_blocked = out_valid_o & out_stall_i;
  assign quiet       = ~in_fire & ~out_blocked;

  // A blocked result word stays valid and unchanged.
  `CRCBS_ASSERT(a_hold, out_blocked |=> out_valid_o && $stable(crc_value_o), "held result changed")

  // The input side only stalls behind a blocked result word.
  `CRCBS_ASSERT_NEVER(a_stall_cause, in_stall_o && !out_blocked, "stall without blocked result")

  // When both this and the past sample show no word accepted and nothing blocked, no result appears.
  `CRCBS_ASSERT(a_no_phantom, $past(quiet) && quiet |=> !out_valid_o, "result with no last byte")

endmodule

bind crc32_byte_stream_top crcbs_checker u_crcbs_checker (.*);

@@ tb/crc32_byte_stream_checker.sv @@
// ----------------------------------------------------------------------------
// CRC-32 byte stream checker
// Watches both channels of the byte stream CRC block and predicts each
// result word from the accepted bytes. Result words are compared in order
// against the predicted CRC values, and failures are counted for the top.
// ----------------------------------------------------------------------------
module crc32_byte_stream_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] crc_value_i,
  output int          fail_count_o,
  output int          pending_o
);

  // Reflected CRC-32 polynomial used by the prediction.
  localparam logic [31:0] ReflectedPoly = 32'hEDB88320;
  localparam int          ReportLimit   = 10;

  logic [31:0] running_crc;
  logic [31:0] crc_expect_q[$];
  int          fail_cnt;

  // Shift one byte through the CRC register, least significant bit first.
  function automatic logic [31:0] crc_absorb_byte(input logic [31:0] crc,
                                                  input logic [7:0]  data);
    logic [31:0] acc;
    acc = crc ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      acc = {1'b0, acc[31:1]} ^ (ReflectedPoly & {32{acc[0]}});
    end
    return acc;
  endfunction

  // Record one failure and report it while under the report limit.
  task automatic note_failure(input string what, input logic [31:0] expected,
                              input logic [31:0] actual);
    if (fail_cnt < ReportLimit) begin
      $display("crc mismatch (%s): expected %08h, got %08h", what, expected, actual);
    end
    fail_cnt++;
  endtask

  // Compare result words first, then fold the accepted byte into the running
  // CRC. A result word always belongs to an earlier byte than this edge's one.
  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] next_crc;
    if (!rst_ni) begin
      running_crc = 32'd0;
      crc_expect_q.delete();
      fail_cnt = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (crc_expect_q.size() == 0) begin
          note_failure("no word expected", 32'd0, crc_value_i);
        end else if (crc_value_i !== crc_expect_q[0]) begin
          note_failure("crc_value", crc_expect_q[0], crc_value_i);
          void'(crc_expect_q.pop_front());
        end else begin
          void'(crc_expect_q.pop_front());
        end
      end
      if (in_valid_i && !in_stall_i) begin
        next_crc = first_byte_i ? 32'd0 : running_crc;
        next_crc = crc_absorb_byte(next_crc, data_byte_i);
        running_crc = next_crc;
        if (last_byte_i) begin
          crc_expect_q.push_back(next_crc);
        end
      end
    end
  end

  assign fail_count_o = fail_cnt;
  assign pending_o    = crc_expect_q.size();

endmodule

@@ tb/crc32_byte_stream_top_test.sv @@
// ----------------------------------------------------------------------------
// CRC-32 byte stream testbench
// Drives directed and random byte messages into the CRC block with random
// gaps and result stalls, including one long result hold-off that backs up
// the input. A checker beside the block predicts and compares every word.
// ----------------------------------------------------------------------------
module crc32_byte_stream_top_test;

  localparam int RandomBytes  = 800;
  localparam int WatchdogMax  = 1000;
  localparam int DrainCycles  = 10;
  localparam int HoldOffAt    = 40;
  localparam int HoldOffLen   = 80;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i  = 8'd0;
  logic        first_byte_i = 1'b0;
  logic        last_byte_i  = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic [31:0] crc_value_o;

  int fail_count;
  int pending;
  int idle_cycles = 0;

  // Sender idling: gaps come in stretches, some of them with no gaps at all.
  int  tx_stretch = 0;
  bit  tx_quiet   = 1'b0;

  crc32_byte_stream_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .first_byte_i (first_byte_i),
    .last_byte_i  (last_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .crc_value_o  (crc_value_o)
  );

  crc32_byte_stream_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .first_byte_i (first_byte_i),
    .last_byte_i  (last_byte_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .crc_value_i  (crc_value_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Clock with a period of 10.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Offer one byte word after a random gap and hold it until it is taken.
  task automatic push_byte(input logic [7:0] data, input logic first,
                           input logic last);
    int gap;
    if (tx_stretch == 0) begin
      tx_stretch = $urandom_range(5, 40);
      tx_quiet   = ($urandom_range(0, 2) == 0);
    end
    tx_stretch--;
    gap = tx_quiet ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= data;
    first_byte_i <= first;
    last_byte_i  <= last;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Send a whole message of random bytes with the given framing flags.
  task automatic push_message(input int len, input bit with_first,
                              input bit with_last, inout int sent);
    for (int i = 0; i < len; i++) begin
      push_byte(8'($urandom), with_first && (i == 0), with_last && (i == len - 1));
      sent++;
    end
  endtask

  // Result side: random stalls per word, one long hold-off to back up input.
  initial begin
    int  hold;
    int  taken;
    int  rx_stretch;
    bit  rx_quiet;
    taken      = 0;
    rx_stretch = 0;
    rx_quiet   = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_stretch == 0) begin
        rx_stretch = $urandom_range(5, 30);
        rx_quiet   = ($urandom_range(0, 2) == 0);
      end
      rx_stretch--;
      hold = rx_quiet ? 0 : $urandom_range(0, 5);
      if (taken == HoldOffAt) begin
        hold = HoldOffLen;
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogMax) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    string digits;
    int    sent;
    int    kind;
    digits = "123456789";
    sent   = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A message without a first flag right after reset starts from zero.
    push_byte(8'hA5, 1'b0, 1'b0);
    push_byte(8'h3C, 1'b0, 1'b1);
    // Single-byte messages at the extremes of the byte.
    push_byte(8'h00, 1'b1, 1'b1);
    push_byte(8'hFF, 1'b1, 1'b1);
    push_byte(8'h80, 1'b1, 1'b1);
    push_byte(8'h01, 1'b1, 1'b1);
    // The usual check string as one message.
    for (int i = 0; i < digits.len(); i++) begin
      push_byte(digits[i], i == 0, i == digits.len() - 1);
    end
    // A byte after a finished message continues from that message's CRC.
    push_byte(8'h5A, 1'b0, 1'b1);
    // A repeated first flag restarts the message.
    push_byte(8'h11, 1'b1, 1'b0);
    push_byte(8'h22, 1'b1, 1'b0);
    push_byte(8'h33, 1'b0, 1'b1);

    // Random phase: mostly framed messages, some broken framing and noise.
    while (sent < RandomBytes) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        push_byte(8'($urandom), 1'($urandom), 1'($urandom));
        sent++;
      end else if (kind == 1) begin
        push_message($urandom_range(1, 8), 1'($urandom), 1'b0, sent);
      end else if (kind == 2) begin
        push_message($urandom_range(1, 8), 1'b0, 1'b1, sent);
      end else begin
        push_message($urandom_range(1, 12), 1'b1, 1'b1, sent);
      end
    end
    in_valid_i <= 1'b0;

    // Drain the outstanding words, then watch for stray ones.
    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
